[src/nsg_pkg.sv]
// shared types, constants and the note-to-frequency table for the sawtooth generator
`default_nettype none

package nsg_pkg;

    localparam int NOTE_BITS     = 7;
    localparam int FREQ_BITS     = 17;  // 392 Hz (note 127) shifted up by 8 octaves
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;
    localparam int SEMITONES     = 12;
    localparam int MAX_OCTAVE    = 10;  // highest octave a 7-bit note can reach
    localparam int BASE_OCTAVE   = 2;   // octave that plays the table unshifted

    localparam logic [FREQ_BITS-1:0] SAMPLE_RATE = 17'd44100;

    // 44100 = 4 * 11025: shift out the power of two, then multiply by 1/11025
    localparam int RATE_SHIFT    = 2;
    localparam int RATE_ODD      = 11025;
    localparam int RATE_ODD_BITS = 14;  // 11025 is below 2**14

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RCP_LO,
        S_RCP_HI,
        S_RED
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [FREQ_BITS-1:0] freq;
    } t_note;

    function automatic logic [FREQ_BITS-1:0] semitone_hz(input logic [3:0] idx);
        logic [FREQ_BITS-1:0] hz;
        case (idx)
            4'd0:    hz = 17'd261;
            4'd1:    hz = 17'd277;
            4'd2:    hz = 17'd293;
            4'd3:    hz = 17'd311;
            4'd4:    hz = 17'd329;
            4'd5:    hz = 17'd349;
            4'd6:    hz = 17'd370;
            4'd7:    hz = 17'd392;
            4'd8:    hz = 17'd415;
            4'd9:    hz = 17'd440;
            4'd10:   hz = 17'd466;
            4'd11:   hz = 17'd494;
            default: hz = '0;
        endcase
        return hz;
    endfunction

    // octave and semitone found by parallel compares against multiples of twelve
    function automatic logic [FREQ_BITS-1:0] note_freq(input logic [NOTE_BITS-1:0] n);
        logic [3:0]           oct;
        logic [NOTE_BITS-1:0] semi;
        logic [FREQ_BITS-1:0] base;
        logic [FREQ_BITS-1:0] f;
        oct  = '0;
        semi = n;
        for (int o = 1; o <= MAX_OCTAVE; o++) begin
            if (n >= NOTE_BITS'(SEMITONES * o)) begin
                oct  = 4'(o);
                semi = n - NOTE_BITS'(SEMITONES * o);
            end
        end
        base = semitone_hz(semi[3:0]);
        if (oct >= 4'(BASE_OCTAVE)) begin
            f = base << (oct - 4'(BASE_OCTAVE));
        end else begin
            f = base >> (4'(BASE_OCTAVE) - oct);
        end
        return f;
    endfunction

endpackage

`default_nettype wire

[src/nsg_front.sv]
// input stage: takes beats, looks up the note frequency, registers the command
`default_nettype none

module nsg_front #(
    parameter int AMPLITUDE_BITS = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_start,
    input  wire logic [nsg_pkg::NOTE_BITS-1:0] i_note_number,
    input  wire logic [AMPLITUDE_BITS-1:0]     i_wave_width,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output nsg_pkg::t_note                     o_note,
    output logic [AMPLITUDE_BITS-1:0]          o_width
);
    import nsg_pkg::*;

    logic                      r_valid;
    t_note                     r_note;
    logic [AMPLITUDE_BITS-1:0] r_width;
    logic                      take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_note.start <= i_start;
            r_note.freq  <= note_freq(i_note_number);
            r_width      <= i_wave_width;
        end
    end

    assign o_valid = r_valid;
    assign o_note  = r_note;
    assign o_width = r_width;

endmodule

`default_nettype wire

[src/nsg_queue.sv]
// small fifo between the front stage and the tone engine
`default_nettype none

module nsg_queue #(
    parameter int AMPLITUDE_BITS = 15
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push_valid,
    output logic                           o_push_ready,
    input  wire nsg_pkg::t_note            i_note,
    input  wire logic [AMPLITUDE_BITS-1:0] i_width,
    output logic                           o_pop_valid,
    input  wire logic                      i_pop,
    output nsg_pkg::t_note                 o_note,
    output logic [AMPLITUDE_BITS-1:0]      o_width
);
    import nsg_pkg::*;

    t_note                     r_note_q  [QUEUE_DEPTH];
    logic [AMPLITUDE_BITS-1:0] r_width_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]      r_wr;
    logic [QPTR_BITS-1:0]      r_rd;
    logic [QPTR_BITS:0]        r_count;
    logic                      push;
    logic                      pop;

    assign o_push_ready = r_count != (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_note_q[r_wr]  <= i_note;
            r_width_q[r_wr] <= i_width;
        end
    end

    assign o_note  = r_note_q[r_rd];
    assign o_width = r_width_q[r_rd];

endmodule

`default_nettype wire

[src/nsg_back.sv]
// tone engine: phase accumulator plus a multi-cycle step unit run at each note start with a nonzero width
`default_nettype none

module nsg_back #(
    parameter int AMPLITUDE_BITS = 15
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    output logic                           o_q_pop,
    input  wire nsg_pkg::t_note            i_q_note,
    input  wire logic [AMPLITUDE_BITS-1:0] i_q_width,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [AMPLITUDE_BITS-1:0]      o_sample
);
    import nsg_pkg::*;

    localparam int PROD_BITS = AMPLITUDE_BITS + FREQ_BITS;
    localparam int DIV_BITS  = PROD_BITS - RATE_SHIFT;      // product over four
    localparam int RCP_SHIFT = DIV_BITS + RATE_ODD_BITS;
    localparam int RCP_BITS  = DIV_BITS + 1;
    localparam int LO_BITS   = DIV_BITS / 2;
    localparam int HI_BITS   = DIV_BITS - LO_BITS;
    localparam int ACC_BITS  = DIV_BITS + RCP_BITS;
    localparam int QUOT_BITS = AMPLITUDE_BITS + 2;  // step is below three widths

    // ceil(2**RCP_SHIFT / 11025), exact floor division for any DIV_BITS-wide dividend
    localparam logic [RCP_BITS-1:0] RCP =
        RCP_BITS'(((64'd1 << RCP_SHIFT) + 64'(RATE_ODD - 1)) / 64'(RATE_ODD));

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_out_valid;
    logic [AMPLITUDE_BITS-1:0] r_sample;
    logic [AMPLITUDE_BITS-1:0] r_held;
    logic [AMPLITUDE_BITS-1:0] r_phase;
    logic [AMPLITUDE_BITS-1:0] r_step;
    logic [FREQ_BITS-1:0]      r_freq;
    logic [DIV_BITS-1:0]       r_div;
    logic [ACC_BITS-1:0]       r_acc;
    logic [QUOT_BITS-1:0]      r_quot;

    logic                      slot_free;
    logic                      pop;
    logic                      pop_start;
    logic                      quot_ge;
    logic [PROD_BITS-1:0]      prod;
    logic [LO_BITS+RCP_BITS-1:0] rcp_lo;
    logic [HI_BITS+RCP_BITS-1:0] rcp_hi;
    logic [ACC_BITS-1:0]       acc_sum;
    logic [AMPLITUDE_BITS:0]   phase_sum;
    logic [AMPLITUDE_BITS-1:0] phase_next;

    assign slot_free = !r_out_valid || i_ready;
    assign prod      = r_held * r_freq;
    assign rcp_lo    = r_div[LO_BITS-1:0] * RCP;
    assign rcp_hi    = r_div[DIV_BITS-1:LO_BITS] * RCP;
    assign acc_sum   = r_acc + {rcp_hi, {LO_BITS{1'b0}}};
    assign quot_ge   = r_quot >= {2'b00, r_held};
    assign phase_sum = {1'b0, r_phase} + {1'b0, r_step};
    assign phase_next = (phase_sum >= {1'b0, r_held})
                      ? AMPLITUDE_BITS'(phase_sum - {1'b0, r_held})
                      : phase_sum[AMPLITUDE_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (pop_start && i_q_width != '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_RCP_LO;
            S_RCP_LO: n_state = S_RCP_HI;
            S_RCP_HI: n_state = S_RED;
            S_RED: begin
                if (!quot_ge) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        pop       = 1'b0;
        pop_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                pop       = i_q_valid && slot_free;
                pop_start = pop && i_q_note.start;
            end
            default: begin
                pop       = 1'b0;
                pop_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_phase     <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop_start) begin
                r_held  <= i_q_width;
                r_phase <= '0;
                r_step  <= '0;
            end else if (pop) begin
                r_phase <= (r_held == '0) ? '0 : phase_next;
            end
            if (r_state == S_RED && !quot_ge) begin
                r_step <= r_quot[AMPLITUDE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_sample <= (pop_start || r_held == '0) ? '0 : phase_next;
        end
        if (pop_start) begin
            r_freq <= i_q_note.freq;
        end
        case (r_state)
            S_MUL: begin
                r_div <= prod[PROD_BITS-1:RATE_SHIFT];
            end
            S_RCP_LO: begin
                r_acc <= ACC_BITS'(rcp_lo);
            end
            S_RCP_HI: begin
                r_quot <= acc_sum[RCP_SHIFT +: QUOT_BITS];
            end
            S_RED: begin
                if (quot_ge) begin
                    r_quot <= r_quot - {2'b00, r_held};
                end
            end
            default: begin
                r_quot <= r_quot;
            end
        endcase
    end

    assign o_q_pop  = pop;
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

[src/note_sawtooth_generator.sv]
// top level of the sawtooth tone generator: front stage, command queue and tone engine
//
// One input beat is one sample tick at 44.1 kHz and gives exactly one output beat. A beat
// with tuser set starts a note: note_number and wave_width are taken, the output is 0 and
// the phase clears. Every later beat adds the per-sample step (width*frequency/44100,
// reduced modulo the width) to the phase and wraps it at the width, so the i-th sample of a
// note is (i*step) mod width. A width of 0 gives silence. Continuing ticks flow at one beat
// per cycle through a registered phase add and wrap while the output does not stall and the
// step unit is idle. A note start with a nonzero width occupies the step unit after it leaves
// the queue: a multiply step, a reciprocal multiply for the divide by 44100 split into a low
// and a high half, and a compare step that repeats with up to two modulo subtracts. Ticks
// behind it wait in a four-entry queue while input beats are accepted until it and the front
// register are full. A tick passes the front register, a queue entry and the sample register.
`default_nettype none

module note_sawtooth_generator #(
    parameter int AMPLITUDE_BITS = 15
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // note_number [6:0], wave_width [AMPLITUDE_BITS+6:7], zero padded to bytes
    input  wire logic [((AMPLITUDE_BITS + 14) / 8) * 8 - 1:0] s_axis_tdata,
    // start_note [0]
    input  wire logic                    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // sample [AMPLITUDE_BITS-1:0], zero padded to bytes
    output logic [((AMPLITUDE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import nsg_pkg::*;

    localparam int OUT_BITS = ((AMPLITUDE_BITS + 7) / 8) * 8;

    // front stage to queue
    logic                      front_valid;
    logic                      front_ready;
    t_note                     front_note;
    logic [AMPLITUDE_BITS-1:0] front_width;

    // queue to tone engine
    logic                      q_valid;
    logic                      q_pop;
    t_note                     q_note;
    logic [AMPLITUDE_BITS-1:0] q_width;

    logic [AMPLITUDE_BITS-1:0] sample;

    nsg_front #(
        .AMPLITUDE_BITS(AMPLITUDE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_start      (s_axis_tuser),
        .i_note_number(s_axis_tdata[NOTE_BITS-1:0]),
        .i_wave_width (s_axis_tdata[NOTE_BITS+AMPLITUDE_BITS-1:NOTE_BITS]),
        .o_valid      (front_valid),
        .i_ready      (front_ready),
        .o_note       (front_note),
        .o_width      (front_width)
    );

    // commands wait here while the engine works out a new step
    nsg_queue #(
        .AMPLITUDE_BITS(AMPLITUDE_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(front_valid),
        .o_push_ready(front_ready),
        .i_note      (front_note),
        .i_width     (front_width),
        .o_pop_valid (q_valid),
        .i_pop       (q_pop),
        .o_note      (q_note),
        .o_width     (q_width)
    );

    nsg_back #(
        .AMPLITUDE_BITS(AMPLITUDE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .o_q_pop  (q_pop),
        .i_q_note (q_note),
        .i_q_width(q_width),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_sample (sample)
    );

    // padding bits above the sample stay zero
    assign m_axis_tdata = OUT_BITS'(sample);

endmodule

`default_nettype wire

[src/nsg_checker.sv]
// port-level checks for the sawtooth generator, bound to the top level
`default_nettype none

module nsg_checker #(
    parameter int AMPLITUDE_BITS = 15
) (
    input wire logic                                         i_clk,
    input wire logic                                         i_rst_n,
    input wire logic                                         s_axis_tvalid,
    input wire logic                                         s_axis_tready,
    input wire logic                                         m_axis_tvalid,
    input wire logic                                         m_axis_tready,
    input wire logic [((AMPLITUDE_BITS + 7) / 8) * 8 - 1:0]  m_axis_tdata
);
    localparam int OUT_BITS = ((AMPLITUDE_BITS + 7) / 8) * 8;

    // ticks taken in but not yet delivered
    logic [3:0] r_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {3'b000, in_beat} - {3'b000, out_beat};
        end
    end

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 4'd0)
        else $error("output beat without a pending input tick");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> AMPLITUDE_BITS) == OUT_BITS'(0))
        else $error("padding bits of the sample beat not zero");

endmodule

bind note_sawtooth_generator nsg_checker #(
    .AMPLITUDE_BITS(AMPLITUDE_BITS)
) u_nsg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
